// ----- src/sct_pkg.sv -----
// Package for the source character tokenizer: types, character codes and
// token kinds shared by the front, queue and back modules.
// Depends on nothing.
`default_nettype none

package sct_pkg;

	localparam int OFFSET_BITS_DEF = 32;
	localparam int QUEUE_DEPTH_DEF = 4;
	localparam logic [15:0] FIRST_LINE_RST = 16'd1;

	localparam logic [7:0] CH_NUL = 8'h00;
	localparam logic [7:0] CH_TAB = 8'h09;
	localparam logic [7:0] CH_NL = 8'h0A;
	localparam logic [7:0] CH_CR = 8'h0D;
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_BANG = 8'h21;
	localparam logic [7:0] CH_QUOTE = 8'h22;
	localparam logic [7:0] CH_SLASH = 8'h2F;
	localparam logic [7:0] CH_ZERO = 8'h30;
	localparam logic [7:0] CH_NINE = 8'h39;
	localparam logic [7:0] CH_LT = 8'h3C;
	localparam logic [7:0] CH_EQ = 8'h3D;
	localparam logic [7:0] CH_GT = 8'h3E;
	localparam logic [7:0] CH_UPPER_A = 8'h41;
	localparam logic [7:0] CH_UPPER_Z = 8'h5A;
	localparam logic [7:0] CH_UNDER = 8'h5F;
	localparam logic [7:0] CH_LOWER_A = 8'h61;
	localparam logic [7:0] CH_LOWER_Z = 8'h7A;

	typedef enum logic [2:0] {
		MODE_IDLE    = 3'd0,
		MODE_NUMBER  = 3'd1,
		MODE_IDENT   = 3'd2,
		MODE_STRING  = 3'd3,
		MODE_OPER    = 3'd4,
		MODE_SLASH   = 3'd5,
		MODE_COMMENT = 3'd6
	} mode_t;

	typedef enum logic [3:0] {
		KIND_END      = 4'd0,
		KIND_NUMBER   = 4'd1,
		KIND_IDENT    = 4'd2,
		KIND_STRING   = 4'd3,
		KIND_NE       = 4'd4,
		KIND_EQEQ     = 4'd5,
		KIND_LE       = 4'd6,
		KIND_GE       = 4'd7,
		KIND_SINGLE   = 4'd8,
		KIND_UNCLOSED = 4'd9
	} kind_t;

	// One classified source byte as it travels through the queue.
	typedef struct packed {
		logic [7:0] ch;
		logic       is_nul;
		logic       is_digit;
		logic       is_alpha;
		logic       is_under;
		logic       is_quote;
		logic       is_slash;
		logic       is_eq;
		logic       is_opstart;
		logic       is_space;
		logic       is_newline;
	} item_t;

	typedef struct packed {
		kind_t        kind;
		logic [7:0]   code;
		logic [63:0]  value;
		logic [31:0]  start;
		logic [31:0]  length;
		logic [15:0]  line;
		logic         last;
	} result_t;

	function automatic item_t classify(input logic [7:0] c);
		item_t it;
		it.ch = c;
		it.is_nul = (c == CH_NUL);
		it.is_digit = (c >= CH_ZERO) && (c <= CH_NINE);
		it.is_alpha = ((c >= CH_LOWER_A) && (c <= CH_LOWER_Z)) ||
			((c >= CH_UPPER_A) && (c <= CH_UPPER_Z));
		it.is_under = (c == CH_UNDER);
		it.is_quote = (c == CH_QUOTE);
		it.is_slash = (c == CH_SLASH);
		it.is_eq = (c == CH_EQ);
		it.is_opstart = (c == CH_BANG) || (c == CH_EQ) || (c == CH_LT) || (c == CH_GT);
		it.is_space = (c == CH_SPACE) || (c == CH_TAB) || (c == CH_CR);
		it.is_newline = (c == CH_NL);
		return it;
	endfunction

endpackage

`default_nettype wire

// ----- src/sct_front.sv -----
// Front end of the tokenizer: accepts source bytes and classifies them into
// a registered item. Depends on sct_pkg.
`default_nettype none

module sct_front (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          in_valid,
	output logic               in_ready,
	input  wire logic [7:0]    ch,
	output logic               item_valid,
	output sct_pkg::item_t     item,
	input  wire logic          item_ready
);

	logic           valid_s1;
	sct_pkg::item_t item_s1;

	// The stage refills in the same cycle that it drains.
	assign in_ready = !valid_s1 || item_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			item_s1 <= sct_pkg::classify(ch);
		end
	end

	assign item_valid = valid_s1;
	assign item = item_s1;

endmodule

`default_nettype wire

// ----- src/sct_queue.sv -----
// Short first-in first-out queue of classified bytes between front and back.
// Depends on sct_pkg.
`default_nettype none

module sct_queue #(
	parameter int DEPTH = sct_pkg::QUEUE_DEPTH_DEF
) (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           push_valid,
	output logic                push_ready,
	input  wire sct_pkg::item_t push_item,
	output logic                head_valid,
	output sct_pkg::item_t      head_item,
	input  wire logic           pop
);

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);
	localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH - 1);
	localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

	sct_pkg::item_t slots_q [DEPTH];
	logic [PW-1:0]  wr_ptr_q;
	logic [PW-1:0]  rd_ptr_q;
	logic [CW-1:0]  count_q;
	logic           do_push;
	logic           do_pop;

	assign push_ready = (count_q != FULL_CNT);
	assign head_valid = (count_q != '0);
	assign head_item = slots_q[rd_ptr_q];
	assign do_push = push_valid && push_ready;
	assign do_pop = pop && head_valid;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == LAST_PTR) ? '0 : wr_ptr_q + PW'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == LAST_PTR) ? '0 : rd_ptr_q + PW'(1);
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + CW'(1);
			end else if (do_pop && !do_push) begin
				count_q <= count_q - CW'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			slots_q[wr_ptr_q] <= push_item;
		end
	end

endmodule

`default_nettype wire

// ----- src/sct_back.sv -----
// Back end of the tokenizer: scan state machine, token building and the
// output register. Depends on sct_pkg.
`default_nettype none

module sct_back #(
	parameter int OFFSET_BITS = sct_pkg::OFFSET_BITS_DEF
) (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           cfg_we,
	input  wire logic [15:0]    cfg_wdata,
	input  wire logic           head_valid,
	input  wire sct_pkg::item_t head_item,
	output logic                pop,
	output logic                out_valid,
	output sct_pkg::result_t    out_result,
	input  wire logic           out_ready
);

	localparam int OB = OFFSET_BITS;
	localparam logic [OB-1:0] ONE_OFF = OB'(1);

	// Offsets are kept at OB bits and shown on 32-bit fields.
	function automatic logic [31:0] to32(input logic [OB-1:0] v);
		logic [OB+31:0] w;
		w = {32'b0, v};
		return w[31:0];
	endfunction

	sct_pkg::mode_t mode_q;
	logic [63:0]    acc_q;
	logic [OB-1:0]  start_q;
	logic [OB-1:0]  pos_q;
	logic [15:0]    line_q;
	logic [7:0]     pend_q;
	logic [15:0]    first_line_q;
	logic           phase_q;
	logic           out_valid_q;
	sct_pkg::result_t out_q;

	sct_pkg::item_t   it;
	sct_pkg::result_t res_a;
	sct_pkg::result_t res_b;
	sct_pkg::result_t res_sel;
	logic             a_valid;
	logic             b_valid;
	logic             done;
	logic             two;
	logic             need_out;
	logic             step;
	logic             commit;
	logic             emit;
	logic [63:0]      digit;
	logic [OB-1:0]    span;
	sct_pkg::mode_t   nx_mode;
	logic [63:0]      nx_acc;
	logic [OB-1:0]    nx_start;
	logic [15:0]      nx_line;
	logic [7:0]       nx_pend;

	assign it = head_item;
	assign digit = {56'b0, it.ch - sct_pkg::CH_ZERO};
	assign span = pos_q - start_q;

	always_comb begin
		res_a = '0;
		res_b = '0;
		res_a.line = line_q;
		res_b.line = line_q;
		res_a.start = to32(start_q);
		res_b.start = to32(pos_q);
		a_valid = 1'b0;
		b_valid = 1'b0;
		done = 1'b0;
		nx_mode = mode_q;
		nx_acc = acc_q;
		nx_start = start_q;
		nx_line = line_q;
		nx_pend = pend_q;

		// Tokens that only the following byte can end are flushed first.
		case (mode_q)
			sct_pkg::MODE_NUMBER: begin
				if (it.is_digit) begin
					done = 1'b1;
					nx_acc = (acc_q << 3) + (acc_q << 1) + digit;
				end else begin
					a_valid = 1'b1;
					res_a.kind = sct_pkg::KIND_NUMBER;
					res_a.value = acc_q;
					res_a.length = to32(span);
					nx_mode = sct_pkg::MODE_IDLE;
				end
			end
			sct_pkg::MODE_IDENT: begin
				if (it.is_alpha || it.is_digit || it.is_under) begin
					done = 1'b1;
				end else begin
					a_valid = 1'b1;
					res_a.kind = sct_pkg::KIND_IDENT;
					res_a.length = to32(span);
					nx_mode = sct_pkg::MODE_IDLE;
				end
			end
			sct_pkg::MODE_OPER: begin
				a_valid = 1'b1;
				nx_mode = sct_pkg::MODE_IDLE;
				if (it.is_eq) begin
					done = 1'b1;
					res_a.length = 32'd2;
					if (pend_q == sct_pkg::CH_BANG) begin
						res_a.kind = sct_pkg::KIND_NE;
					end else if (pend_q == sct_pkg::CH_EQ) begin
						res_a.kind = sct_pkg::KIND_EQEQ;
					end else if (pend_q == sct_pkg::CH_LT) begin
						res_a.kind = sct_pkg::KIND_LE;
					end else begin
						res_a.kind = sct_pkg::KIND_GE;
					end
				end else begin
					res_a.kind = sct_pkg::KIND_SINGLE;
					res_a.code = pend_q;
					res_a.length = 32'd1;
				end
			end
			sct_pkg::MODE_SLASH: begin
				if (it.is_slash) begin
					done = 1'b1;
					nx_mode = sct_pkg::MODE_COMMENT;
				end else begin
					a_valid = 1'b1;
					res_a.kind = sct_pkg::KIND_SINGLE;
					res_a.code = sct_pkg::CH_SLASH;
					res_a.length = 32'd1;
					nx_mode = sct_pkg::MODE_IDLE;
				end
			end
			sct_pkg::MODE_STRING: begin
				done = 1'b1;
				if (it.is_quote) begin
					a_valid = 1'b1;
					res_a.kind = sct_pkg::KIND_STRING;
					res_a.length = to32(span + ONE_OFF);
					nx_mode = sct_pkg::MODE_IDLE;
				end else if (it.is_nul) begin
					a_valid = 1'b1;
					res_a.kind = sct_pkg::KIND_UNCLOSED;
					res_a.length = to32(span);
					b_valid = 1'b1;
					res_b.kind = sct_pkg::KIND_END;
				end
			end
			sct_pkg::MODE_COMMENT: begin
				done = 1'b1;
				if (it.is_newline) begin
					nx_line = line_q + 16'd1;
					nx_mode = sct_pkg::MODE_IDLE;
				end else if (it.is_nul) begin
					b_valid = 1'b1;
					res_b.kind = sct_pkg::KIND_END;
				end
			end
			default: begin
				nx_mode = sct_pkg::MODE_IDLE;
			end
		endcase

		if (!done) begin
			nx_start = pos_q;
			if (it.is_nul) begin
				b_valid = 1'b1;
				res_b.kind = sct_pkg::KIND_END;
			end else if (it.is_digit) begin
				nx_mode = sct_pkg::MODE_NUMBER;
				nx_acc = digit;
			end else if (it.is_alpha) begin
				nx_mode = sct_pkg::MODE_IDENT;
			end else if (it.is_quote) begin
				nx_mode = sct_pkg::MODE_STRING;
			end else if (it.is_slash) begin
				nx_mode = sct_pkg::MODE_SLASH;
			end else if (it.is_opstart) begin
				nx_mode = sct_pkg::MODE_OPER;
				nx_pend = it.ch;
			end else if (it.is_space) begin
				nx_mode = sct_pkg::MODE_IDLE;
			end else if (it.is_newline) begin
				nx_line = line_q + 16'd1;
			end else begin
				b_valid = 1'b1;
				res_b.kind = sct_pkg::KIND_SINGLE;
				res_b.code = it.ch;
				res_b.length = 32'd1;
			end
		end
	end

	// A byte with two results holds the queue head until its second result is emitted.
	assign two = a_valid && b_valid;
	assign need_out = a_valid || b_valid;
	assign step = head_valid && (!need_out || !out_valid_q || out_ready);
	assign commit = step && (!two || phase_q);
	assign emit = step && need_out;
	assign pop = commit;

	always_comb begin
		if (phase_q || !a_valid) begin
			res_sel = res_b;
		end else begin
			res_sel = res_a;
		end
		res_sel.last = !two || phase_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= sct_pkg::MODE_IDLE;
			acc_q <= '0;
			start_q <= '0;
			pos_q <= '0;
			line_q <= sct_pkg::FIRST_LINE_RST;
			pend_q <= '0;
			first_line_q <= sct_pkg::FIRST_LINE_RST;
			phase_q <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (commit) begin
				if (it.is_nul) begin
					mode_q <= sct_pkg::MODE_IDLE;
					acc_q <= '0;
					start_q <= '0;
					pos_q <= '0;
					line_q <= first_line_q;
					pend_q <= '0;
				end else begin
					mode_q <= nx_mode;
					acc_q <= nx_acc;
					start_q <= nx_start;
					pos_q <= pos_q + ONE_OFF;
					line_q <= nx_line;
					pend_q <= nx_pend;
				end
			end
			if (cfg_we) begin
				first_line_q <= cfg_wdata;
				if (mode_q == sct_pkg::MODE_IDLE && pos_q == '0) begin
					line_q <= cfg_wdata;
				end
			end
			if (commit) begin
				phase_q <= 1'b0;
			end else if (emit) begin
				phase_q <= 1'b1;
			end
			if (emit) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			out_q <= res_sel;
		end
	end

	assign out_valid = out_valid_q;
	assign out_result = out_q;

	// The second result of a byte is only pending while that byte is at the head.
	a_phase_head: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q |-> head_valid)
		else $error("second-result phase without a queued byte");

	// A result that is not the last of its byte is followed by the second phase.
	a_phase_follows: assert property (@(posedge clk) disable iff (!arst_n)
		emit && !res_sel.last |=> phase_q)
		else $error("first of two results not followed by second phase");

	// End of source returns the scanner to its start state.
	a_nul_clears: assert property (@(posedge clk) disable iff (!arst_n)
		commit && it.is_nul |=> mode_q == sct_pkg::MODE_IDLE && pos_q == '0)
		else $error("end of source did not clear scan state");

	// A byte that is retired with a result always loads the output register.
	a_commit_emits: assert property (@(posedge clk) disable iff (!arst_n)
		commit && need_out |=> out_valid_q)
		else $error("retired byte lost its result");

endmodule

`default_nettype wire

// ----- src/source_char_tokenizer_top.sv -----
// A byte passes the front register and the queue before the output register.
// Throughput: one byte per cycle unless the output stalls; a byte with two
// results holds the back end until both are in the single output register. A
// short queue lets the front keep taking bytes meanwhile. Reset (arst_n low)
// clears all control and scan state at once, sets first_line to 1, and needs no
// clearing pass. Depends on sct_pkg, sct_front, sct_queue and sct_back.
`default_nettype none

module source_char_tokenizer_top #(
	parameter int OFFSET_BITS = sct_pkg::OFFSET_BITS_DEF,
	parameter int QUEUE_DEPTH = sct_pkg::QUEUE_DEPTH_DEF
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        cfg_we,
	input  wire logic [15:0] cfg_wdata,
	input  wire logic        in_valid,
	output logic             in_ready,
	input  wire logic [7:0]  ch,
	output logic             out_valid,
	input  wire logic        out_ready,
	output logic [3:0]       token_kind,
	output logic [7:0]       char_code,
	output logic [63:0]      number_value,
	output logic [31:0]      token_start,
	output logic [31:0]      token_length,
	output logic [15:0]      line_number,
	output logic             last
);

	// The front registers and classifies each byte transfer; the queue
	// decouples it from the back end, which runs the scan state machine.
	logic             f_valid;
	logic             f_ready;
	sct_pkg::item_t   f_item;
	logic             q_valid;
	sct_pkg::item_t   q_item;
	logic             q_pop;
	sct_pkg::result_t result;

	sct_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.ch         (ch),
		.item_valid (f_valid),
		.item       (f_item),
		.item_ready (f_ready)
	);

	sct_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (f_valid),
		.push_ready (f_ready),
		.push_item  (f_item),
		.head_valid (q_valid),
		.head_item  (q_item),
		.pop        (q_pop)
	);

	// The back end holds first_line and loads the line count from it when a
	// write arrives at the start of source.
	sct_back #(
		.OFFSET_BITS (OFFSET_BITS)
	) u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_wdata  (cfg_wdata),
		.head_valid (q_valid),
		.head_item  (q_item),
		.pop        (q_pop),
		.out_valid  (out_valid),
		.out_result (result),
		.out_ready  (out_ready)
	);

	assign token_kind = result.kind;
	assign char_code = result.code;
	assign number_value = result.value;
	assign token_start = result.start;
	assign token_length = result.length;
	assign line_number = result.line;
	assign last = result.last;

endmodule

`default_nettype wire

// ----- test/tb_source_char_tokenizer_top.sv -----
// Self-checking testbench for source_char_tokenizer_top: directed and random source
// text, with a byte-level token predictor and valid/ready traffic on both sides.
// Depends on sct_pkg and source_char_tokenizer_top.
`timescale 1ns / 1ps

module tb_source_char_tokenizer_top;
	import sct_pkg::*;

	// Generous bound on the whole run; the slowest legal run is far shorter.
	localparam int CYCLE_LIMIT = 300000;
	// Bytes of random source text to generate after the directed part.
	localparam int RANDOM_BYTES = 1500;
	// Cycles to wait after the last expected token before touching the register,
	// so that bytes which produce no token can leave the pipeline and its queue.
	localparam int SETTLE_CYCLES = 16;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        cfg_we = 1'b0;
	logic [15:0] cfg_wdata = 16'd0;
	logic        in_valid = 1'b0;
	logic        in_ready;
	logic [7:0]  src_ch = 8'd0;
	logic        out_valid;
	logic        out_ready = 1'b0;
	logic [3:0]  token_kind;
	logic [7:0]  char_code;
	logic [63:0] number_value;
	logic [31:0] token_start;
	logic [31:0] token_length;
	logic [15:0] line_number;
	logic        tok_last;

	source_char_tokenizer_top u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_wdata(cfg_wdata),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.ch(src_ch),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.token_kind(token_kind),
		.char_code(char_code),
		.number_value(number_value),
		.token_start(token_start),
		.token_length(token_length),
		.line_number(line_number),
		.last(tok_last)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	// Source bytes waiting to be sent, and tokens the scanner must still produce.
	logic [7:0] src_bytes [$];
	result_t    expected_tokens [$];

	int bytes_planned = 0;
	int bytes_sent = 0;
	int sources_ended = 0;
	int tokens_checked = 0;
	int cfg_writes = 0;
	int error_count = 0;
	int cycle_count = 0;

	// Scanner state as the predictor sees it. These mirror the state after reset.
	mode_t       sc_mode = MODE_IDLE;
	logic [63:0] sc_acc = 64'd0;
	logic [31:0] sc_tok_start = 32'd0;
	logic [31:0] sc_pos = 32'd0;
	logic [15:0] sc_line = FIRST_LINE_RST;
	logic [7:0]  sc_op_char = 8'd0;
	logic [15:0] sc_first_line = FIRST_LINE_RST;

	// Tokens produced by the byte currently being predicted (at most two).
	result_t step_tok [2];
	int      step_n;

	function automatic logic digit_byte(input logic [7:0] c);
		return (c >= CH_ZERO) && (c <= CH_NINE);
	endfunction

	function automatic logic letter_byte(input logic [7:0] c);
		return ((c >= CH_LOWER_A) && (c <= CH_LOWER_Z)) ||
			((c >= CH_UPPER_A) && (c <= CH_UPPER_Z));
	endfunction

	// A token is stamped with the line count at the moment it is emitted.
	task automatic add_token(input kind_t k, input logic [7:0] code, input logic [63:0] val,
			input logic [31:0] st, input logic [31:0] len);
		result_t r;
		r.kind = k;
		r.code = code;
		r.value = val;
		r.start = st;
		r.length = len;
		r.line = sc_line;
		r.last = 1'b0;
		step_tok[step_n] = r;
		step_n++;
	endtask

	// Predicts the tokens caused by one accepted source byte and advances the
	// scanner state. A pending number, identifier, operator or slash is closed
	// first by the byte that follows it; that byte is then scanned on its own
	// unless it was absorbed into the pending token.
	task automatic scan_byte(input logic [7:0] c);
		logic        consumed;
		logic        finish;
		logic [31:0] pos;
		kind_t       op_kind;
		pos = sc_pos;
		consumed = 1'b0;
		finish = 1'b0;
		step_n = 0;

		case (sc_mode)
			MODE_NUMBER: begin
				if (digit_byte(c)) begin
					// The value simply wraps when it outgrows 64 bits.
					sc_acc = sc_acc * 64'd10 + 64'(c - CH_ZERO);
					consumed = 1'b1;
				end else begin
					add_token(KIND_NUMBER, 8'd0, sc_acc, sc_tok_start, pos - sc_tok_start);
					sc_mode = MODE_IDLE;
				end
			end
			MODE_IDENT: begin
				if (letter_byte(c) || digit_byte(c) || c == CH_UNDER) begin
					consumed = 1'b1;
				end else begin
					add_token(KIND_IDENT, 8'd0, 64'd0, sc_tok_start, pos - sc_tok_start);
					sc_mode = MODE_IDLE;
				end
			end
			MODE_OPER: begin
				if (c == CH_EQ) begin
					case (sc_op_char)
						CH_BANG: op_kind = KIND_NE;
						CH_EQ:   op_kind = KIND_EQEQ;
						CH_LT:   op_kind = KIND_LE;
						default: op_kind = KIND_GE;
					endcase
					add_token(op_kind, 8'd0, 64'd0, sc_tok_start, 32'd2);
					sc_mode = MODE_IDLE;
					consumed = 1'b1;
				end else begin
					// A lone operator character becomes a single-character token.
					add_token(KIND_SINGLE, sc_op_char, 64'd0, sc_tok_start, 32'd1);
					sc_mode = MODE_IDLE;
				end
			end
			MODE_SLASH: begin
				if (c == CH_SLASH) begin
					sc_mode = MODE_COMMENT;
					consumed = 1'b1;
				end else begin
					add_token(KIND_SINGLE, CH_SLASH, 64'd0, sc_tok_start, 32'd1);
					sc_mode = MODE_IDLE;
				end
			end
			MODE_STRING: begin
				// Everything up to the closing quote belongs to the string,
				// newlines included, and they do not advance the line count.
				consumed = 1'b1;
				if (c == CH_QUOTE) begin
					add_token(KIND_STRING, 8'd0, 64'd0, sc_tok_start,
						pos - sc_tok_start + 32'd1);
					sc_mode = MODE_IDLE;
				end else if (c == CH_NUL) begin
					add_token(KIND_UNCLOSED, 8'd0, 64'd0, sc_tok_start, pos - sc_tok_start);
					add_token(KIND_END, 8'd0, 64'd0, pos, 32'd0);
					finish = 1'b1;
				end
			end
			MODE_COMMENT: begin
				consumed = 1'b1;
				if (c == CH_NL) begin
					sc_line = sc_line + 16'd1;
					sc_mode = MODE_IDLE;
				end else if (c == CH_NUL) begin
					// End of source inside a comment gives only the end token.
					add_token(KIND_END, 8'd0, 64'd0, pos, 32'd0);
					finish = 1'b1;
				end
			end
			default: sc_mode = MODE_IDLE;
		endcase

		if (!consumed) begin
			sc_tok_start = pos;
			if (c == CH_NUL) begin
				add_token(KIND_END, 8'd0, 64'd0, pos, 32'd0);
				finish = 1'b1;
			end else if (digit_byte(c)) begin
				sc_mode = MODE_NUMBER;
				sc_acc = 64'(c - CH_ZERO);
			end else if (letter_byte(c)) begin
				sc_mode = MODE_IDENT;
			end else if (c == CH_QUOTE) begin
				sc_mode = MODE_STRING;
			end else if (c == CH_SLASH) begin
				sc_mode = MODE_SLASH;
			end else if (c == CH_BANG || c == CH_EQ || c == CH_LT || c == CH_GT) begin
				sc_mode = MODE_OPER;
				sc_op_char = c;
			end else if (c == CH_NL) begin
				sc_line = sc_line + 16'd1;
			end else if (c != CH_SPACE && c != CH_TAB && c != CH_CR) begin
				// Anything else, underscore and high bytes included, stands alone.
				add_token(KIND_SINGLE, c, 64'd0, pos, 32'd1);
			end
		end

		if (step_n > 0)
			step_tok[step_n - 1].last = 1'b1;
		for (int i = 0; i < step_n; i++)
			expected_tokens.push_back(step_tok[i]);

		// End of source returns the scanner to its reset state, except that the
		// line count restarts from the current first_line setting.
		if (finish) begin
			sc_mode = MODE_IDLE;
			sc_acc = 64'd0;
			sc_tok_start = 32'd0;
			sc_pos = 32'd0;
			sc_line = sc_first_line;
			sc_op_char = 8'd0;
			sources_ended++;
		end else begin
			sc_pos = pos + 32'd1;
		end
	endtask

	// Sender. It works in bursts of random length separated by random gaps; a
	// gap of zero chains bursts into long stretches without idling. Valid only
	// changes when the slot is empty or its transfer completes at this edge.
	int burst_left = 1;
	int gap_left = 0;

	always @(posedge clk) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
			src_ch <= 8'd0;
		end else begin
			if (in_valid && in_ready) begin
				scan_byte(src_ch);
				bytes_sent++;
			end
			if (!in_valid || in_ready) begin
				if (gap_left > 0) begin
					gap_left--;
					in_valid <= 1'b0;
				end else if (src_bytes.size() > 0) begin
					in_valid <= 1'b1;
					src_ch <= src_bytes.pop_front();
					if (burst_left <= 1) begin
						burst_left = $urandom_range(1, 40);
						gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
					end else begin
						burst_left--;
					end
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	task automatic report_mismatch(input string field, input logic [63:0] got,
			input logic [63:0] want);
		error_count++;
		$display("%0d ns: token mismatch in %s: got %0h, expected %0h",
			$time, field, got, want);
	endtask

	// Compares one token transfer with the oldest expected token.
	task automatic check_token();
		result_t want;
		if (expected_tokens.size() == 0) begin
			report_mismatch("token with none expected, kind", 64'(token_kind), 64'd0);
			return;
		end
		want = expected_tokens.pop_front();
		tokens_checked++;
		if (token_kind != want.kind)
			report_mismatch("token_kind", 64'(token_kind), 64'(want.kind));
		if (char_code != want.code)
			report_mismatch("char_code", 64'(char_code), 64'(want.code));
		if (number_value != want.value)
			report_mismatch("number_value", number_value, want.value);
		if (token_start != want.start)
			report_mismatch("token_start", 64'(token_start), 64'(want.start));
		if (token_length != want.length)
			report_mismatch("token_length", 64'(token_length), 64'(want.length));
		if (line_number != want.line)
			report_mismatch("line_number", 64'(line_number), 64'(want.line));
		if (tok_last != want.last)
			report_mismatch("last", 64'(tok_last), 64'(want.last));
	endtask

	// Receiver and checker. The stall style is redrawn at random among: always
	// ready, random, ready at regular intervals, or long stalls with short openings.
	int stall_style = 0;
	int stall_cnt = 0;

	always @(posedge clk) begin
		if (!arst_n) begin
			out_ready <= 1'b0;
		end else begin
			if (out_valid && out_ready)
				check_token();
			stall_cnt++;
			if (stall_cnt % 97 == 0)
				stall_style = $urandom_range(0, 3);
			case (stall_style)
				0:       out_ready <= 1'b1;
				1:       out_ready <= 1'($urandom_range(0, 1));
				2:       out_ready <= (stall_cnt % 3 == 0);
				default: out_ready <= (stall_cnt % 8 >= 6);
			endcase
		end
	end

	// Watchdog for a hung handshake or a lost token.
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d tokens still expected",
				cycle_count, expected_tokens.size());
			$display("tb_source_char_tokenizer_top: done, errors");
			$finish;
		end
	end

	function automatic void queue_byte(input logic [7:0] b);
		src_bytes.push_back(b);
		bytes_planned++;
	endfunction

	function automatic void queue_text(input string s);
		for (int i = 0; i < s.len(); i++)
			queue_byte(s[i]);
	endfunction

	function automatic logic [7:0] pick_space();
		case ($urandom_range(0, 3))
			0:       return CH_SPACE;
			1:       return CH_TAB;
			2:       return CH_CR;
			default: return CH_NL;
		endcase
	endfunction

	function automatic logic [7:0] pick_op();
		case ($urandom_range(0, 3))
			0:       return CH_BANG;
			1:       return CH_EQ;
			2:       return CH_LT;
			default: return CH_GT;
		endcase
	endfunction

	function automatic logic [7:0] pick_letter();
		return ($urandom_range(0, 1) ? CH_LOWER_A : CH_UPPER_A) + 8'($urandom_range(0, 25));
	endfunction

	// Body of a string or comment: any non-zero byte except the one that ends it.
	// Newlines are favored so that strings often span lines.
	function automatic void queue_body(input logic [7:0] stop, input int len);
		logic [7:0] b;
		for (int i = 0; i < len; i++) begin
			if ($urandom_range(0, 5) == 0)
				b = CH_NL;
			else
				b = 8'($urandom_range(1, 255));
			if (b == stop)
				b = CH_UPPER_A;
			queue_byte(b);
		end
	endfunction

	// One random source: mostly a run of well-formed tokens, sometimes adjacent
	// and sometimes separated by whitespace, then an ending. A few sources are
	// pure noise, and some are left open so that the next one continues them.
	task automatic gen_source();
		string punct;
		int    n_tok;
		int    len;
		punct = "(){};,.+-*_#";
		if ($urandom_range(0, 5) == 0) begin
			len = $urandom_range(4, 30);
			for (int i = 0; i < len; i++)
				queue_byte(8'($urandom_range(0, 255)));
			queue_byte(CH_NUL);
			return;
		end
		n_tok = $urandom_range(1, 12);
		for (int i = 0; i < n_tok; i++) begin
			case ($urandom_range(0, 7))
				0: begin
					// Occasionally long enough to wrap the 64-bit value.
					len = ($urandom_range(0, 7) == 0) ? $urandom_range(19, 24)
						: $urandom_range(1, 5);
					for (int j = 0; j < len; j++)
						queue_byte(CH_ZERO + 8'($urandom_range(0, 9)));
				end
				1: begin
					queue_byte(pick_letter());
					len = $urandom_range(0, 8);
					for (int j = 0; j < len; j++) begin
						case ($urandom_range(0, 2))
							0:       queue_byte(pick_letter());
							1:       queue_byte(CH_ZERO + 8'($urandom_range(0, 9)));
							default: queue_byte(CH_UNDER);
						endcase
					end
				end
				2: begin
					queue_byte(CH_QUOTE);
					queue_body(CH_QUOTE, $urandom_range(0, 10));
					queue_byte(CH_QUOTE);
				end
				3: begin
					queue_byte(pick_op());
					queue_byte(CH_EQ);
				end
				4: queue_byte(($urandom_range(0, 4) == 0) ? CH_SLASH : pick_op());
				5: begin
					if ($urandom_range(0, 2) == 0)
						queue_byte(8'($urandom_range(128, 255)));
					else
						queue_byte(punct[$urandom_range(0, punct.len() - 1)]);
				end
				6: begin
					queue_byte(CH_SLASH);
					queue_byte(CH_SLASH);
					queue_body(CH_NL, $urandom_range(0, 8));
					queue_byte(CH_NL);
				end
				default: queue_byte(pick_space());
			endcase
			if ($urandom_range(0, 1))
				queue_byte(pick_space());
		end
		case ($urandom_range(0, 9))
			0: begin
				queue_byte(CH_QUOTE);
				queue_body(CH_QUOTE, $urandom_range(0, 6));
				queue_byte(CH_NUL);
			end
			1: begin
				queue_byte(CH_SLASH);
				queue_byte(CH_SLASH);
				queue_body(CH_NL, $urandom_range(0, 6));
				queue_byte(CH_NUL);
			end
			2: ;
			default: queue_byte(CH_NUL);
		endcase
	endtask

	// Holds the sender back until every queued byte has been transferred and
	// every expected token has arrived, then lets the pipeline settle.
	task automatic wait_drained();
		do
			@(negedge clk);
		while (src_bytes.size() != 0 || in_valid || expected_tokens.size() != 0);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	// The register always applies from the next end of source; at the very
	// start of a source it also reloads the line count at once.
	task automatic write_first_line(input logic [15:0] v);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_wdata <= v;
		sc_first_line = v;
		if (sc_mode == MODE_IDLE && sc_pos == 32'd0)
			sc_line = v;
		cfg_writes++;
		@(posedge clk);
		cfg_we <= 1'b0;
		@(negedge clk);
	endtask

	function automatic logic [15:0] pick_first_line();
		case ($urandom_range(0, 4))
			0:       return 16'd0;
			1:       return 16'hFFFF;
			2:       return 16'hFFFE;
			3:       return 16'd1;
			default: return 16'($urandom_range(0, 65535));
		endcase
	endfunction

	initial begin
		// Identifier with underscore and digit, all four two-character
		// operators, lone operators ended by other operators, a lone slash,
		// the top byte value, a string with an embedded newline, a comment
		// closed by a newline, and end of source.
		queue_text("a_9!===<=>=!<>/");
		queue_byte(8'hFF);
		queue_text("\"\n\"//c\n");
		queue_byte(CH_NUL);

		repeat (11) @(posedge clk);
		arst_n <= 1'b1;

		// Highest first line, so the newline below wraps the line count to zero.
		wait_drained();
		write_first_line(16'hFFFF);
		// Underscore on its own, a lone '=' ended by a tab, a number ended by a
		// carriage return, a newline, and a string left open at end of source.
		queue_text("_ =\t1");
		queue_byte(CH_CR);
		queue_text("\n\"");
		queue_byte(CH_NUL);

		wait_drained();
		write_first_line(16'd0);
		// End of source inside a comment.
		queue_text("//");
		queue_byte(CH_NUL);

		// Random sources. Now and then the sender pauses until everything has
		// come back, and the line register is often rewritten at that point,
		// sometimes in the middle of a source left open.
		while (bytes_planned < RANDOM_BYTES) begin
			gen_source();
			if ($urandom_range(0, 3) == 0) begin
				wait_drained();
				if ($urandom_range(0, 1))
					write_first_line(pick_first_line());
			end
		end

		wait_drained();
		$display("covered %0d source bytes in %0d ended sources, %0d tokens compared",
			bytes_sent, sources_ended, tokens_checked);
		$display("first_line rewritten %0d times, %0d field mismatches", cfg_writes,
			error_count);
		if (error_count == 0)
			$display("tb_source_char_tokenizer_top: done, clean");
		else
			$display("tb_source_char_tokenizer_top: done, errors");
		$finish;
	end

endmodule

// ----- sim.f -----
src/sct_pkg.sv
src/sct_front.sv
src/sct_queue.sv
src/sct_back.sv
src/source_char_tokenizer_top.sv
test/tb_source_char_tokenizer_top.sv
